### sv/arm_forward_kinematics_assert.svh
// Assertion helpers for the arm kinematics RTL.
`ifndef ARM_FORWARD_KINEMATICS_ASSERT_SVH
`define ARM_FORWARD_KINEMATICS_ASSERT_SVH

`define AFK_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("assertion failed");

`define AFK_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("assertion failed");

`endif

### sv/afk_pkg.sv
`timescale 1ns / 1ps
package afk_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TURN              = 46080;
    localparam int HALF_TURN         = 23040;
    localparam int QUARTER_TURN      = 11520;
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_LINK1  = 3'd1;
    localparam logic [2:0] REG_LINK2  = 3'd2;
    localparam logic [2:0] REG_LINK3  = 3'd3;
    localparam logic [2:0] REG_X_OFFS = 3'd4;
    localparam logic [2:0] REG_Z_OFFS = 3'd5;

    typedef struct packed {
        logic               valid;
        logic [1:0]         idx;
        logic               neg;
        logic signed [15:0] pitch;
    } t_side;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [28:0] z;
    } t_cord;

    typedef struct packed {
        logic               mode;
        logic [15:0]        len1;
        logic [15:0]        len2;
        logic [15:0]        len3;
        logic signed [15:0] x_offs;
        logic signed [15:0] z_offs;
    } t_cfg;

    function automatic logic signed [28:0] atan_val(input int i);
        logic signed [28:0] v;
        case (i)
            0:       v = 29'sd47185920;
            1:       v = 29'sd27855475;
            2:       v = 29'sd14718068;
            3:       v = 29'sd7471121;
            4:       v = 29'sd3750058;
            5:       v = 29'sd1876857;
            6:       v = 29'sd938658;
            7:       v = 29'sd469357;
            8:       v = 29'sd234682;
            9:       v = 29'sd117342;
            10:      v = 29'sd58671;
            11:      v = 29'sd29335;
            12:      v = 29'sd14668;
            13:      v = 29'sd7334;
            14:      v = 29'sd3667;
            15:      v = 29'sd1833;
            16:      v = 29'sd917;
            17:      v = 29'sd458;
            18:      v = 29'sd229;
            19:      v = 29'sd115;
            20:      v = 29'sd57;
            21:      v = 29'sd29;
            22:      v = 29'sd14;
            23:      v = 29'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] wrap_angle(input logic signed [18:0] a);
        logic signed [20:0] t;
        logic signed [20:0] c;
        logic signed [20:0] r;
        t = 21'(a) + 21'(HALF_TURN);
        r = t;
        for (int k = -4; k <= 4; k++) begin
            c = t - 21'(k * TURN);
            if (c >= 0 && c < 21'(TURN)) begin
                r = c;
            end
        end
        return 16'(r - 21'(HALF_TURN));
    endfunction

    function automatic logic signed [18:0] sat19(input logic signed [23:0] v);
        logic signed [18:0] r;
        if (v < -24'sd262144) begin
            r = -19'sd262144;
        end else if (v > 24'sd262143) begin
            r = 19'sd262143;
        end else begin
            r = 19'(v);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v < -18'sd32768) begin
            r = -16'sd32768;
        end else if (v > 18'sd32767) begin
            r = 16'sd32767;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

### sv/afk_cordic_cell.sv
`timescale 1ns / 1ps
module afk_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  afk_pkg::t_side i_side,
    input  afk_pkg::t_cord i_cord,
    output afk_pkg::t_side o_side,
    output afk_pkg::t_cord o_cord
);
    import afk_pkg::*;

    localparam logic signed [28:0] ATAN = atan_val(STAGE);

    t_cord n_cord;
    t_cord r_cord;
    t_side r_side;

    always_comb begin
        n_cord = i_cord;
        if (i_cord.z >= 0) begin
            n_cord.x = i_cord.x - (i_cord.y >>> STAGE);
            n_cord.y = i_cord.y + (i_cord.x >>> STAGE);
            n_cord.z = i_cord.z - ATAN;
        end else begin
            n_cord.x = i_cord.x + (i_cord.y >>> STAGE);
            n_cord.y = i_cord.y - (i_cord.x >>> STAGE);
            n_cord.z = i_cord.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else begin
            r_side.valid <= i_side.valid;
        end
        r_side.idx   <= i_side.idx;
        r_side.neg   <= i_side.neg;
        r_side.pitch <= i_side.pitch;
        r_cord       <= n_cord;
    end

    assign o_side = r_side;
    assign o_cord = r_cord;

endmodule

### sv/afk_accum.sv
`timescale 1ns / 1ps
module afk_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  afk_pkg::t_cfg       i_cfg,
    input  afk_pkg::t_side      i_side,
    input  afk_pkg::t_cord      i_cord,
    output logic                o_done,
    output logic                o_pose_valid,
    output logic signed [18:0]  o_x_pos,
    output logic signed [18:0]  o_y_pos,
    output logic signed [18:0]  o_z_pos,
    output logic signed [15:0]  o_pitch_cos,
    output logic signed [15:0]  o_pitch_sin,
    output logic signed [15:0]  o_pitch_angle
);
    import afk_pkg::*;

    logic signed [31:0] w_c;
    logic signed [31:0] w_s;
    logic [15:0]        w_len;
    logic signed [48:0] w_lenx;
    logic signed [48:0] w_cx;
    logic signed [48:0] w_sx;
    logic signed [31:0] w_c15;
    logic signed [31:0] w_s15;

    logic               r_pv;
    logic [1:0]         r_pidx;
    logic signed [15:0] r_ppitch;
    logic signed [48:0] r_pc;
    logic signed [48:0] r_ps;
    logic signed [31:0] r_pcb;
    logic signed [31:0] r_psb;
    logic signed [15:0] r_hcos;
    logic signed [15:0] r_hsin;

    logic signed [49:0] r_accc;
    logic signed [49:0] r_accs;
    logic signed [49:0] w_sumc;
    logic signed [49:0] w_sums;
    logic signed [49:0] w_r12w;
    logic signed [49:0] w_zw;
    logic signed [23:0] w_z;

    logic               r_mv;
    logic signed [30:0] r_r12;
    logic signed [31:0] r_cb;
    logic signed [31:0] r_sb;
    logic signed [18:0] r_mz;
    logic signed [15:0] r_mcos;
    logic signed [15:0] r_msin;
    logic signed [15:0] r_mpitch;

    logic signed [62:0] w_r12x;
    logic signed [62:0] w_cbx;
    logic signed [62:0] w_sbx;
    logic               r_fv;
    logic signed [62:0] r_px;
    logic signed [62:0] r_py;
    logic signed [18:0] r_fz;
    logic signed [15:0] r_fcos;
    logic signed [15:0] r_fsin;
    logic signed [15:0] r_fpitch;

    logic signed [62:0] w_xr;
    logic signed [62:0] w_yr;
    logic signed [23:0] w_x;
    logic signed [23:0] w_y;

    always_comb begin
        w_c = i_side.neg ? -i_cord.x : i_cord.x;
        w_s = i_side.neg ? -i_cord.y : i_cord.y;
        case (i_side.idx)
            2'd0:    w_len = i_cfg.len1;
            2'd1:    w_len = i_cfg.len2;
            2'd2:    w_len = i_cfg.len3;
            default: w_len = '0;
        endcase
        w_lenx = 49'(signed'({1'b0, w_len}));
        w_cx   = 49'(w_c);
        w_sx   = 49'(w_s);
        w_c15  = (w_c + 32'sd16384) >>> 15;
        w_s15  = (w_s + 32'sd16384) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_side.valid;
        end
        r_pidx   <= i_side.idx;
        r_ppitch <= i_side.pitch;
        r_pc     <= w_lenx * w_cx;
        r_ps     <= w_lenx * w_sx;
        r_pcb    <= w_c;
        r_psb    <= w_s;
        if (i_side.valid && i_side.idx == 2'd2) begin
            r_hcos <= sat16(18'(w_c15));
            r_hsin <= sat16(18'(w_s15));
        end
    end

    always_comb begin
        w_sumc = r_accc + 50'(r_pc);
        w_sums = r_accs + 50'(r_ps);
        w_r12w = (r_accc + 50'sd131072) >>> 18;
        w_zw   = (r_accs + 50'sd536870912) >>> 30;
        w_z    = 24'(w_zw) + 24'(i_cfg.z_offs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_pv && r_pidx == 2'd3;
        end
        if (r_pv) begin
            case (r_pidx)
                2'd0: begin
                    r_accc <= 50'(r_pc);
                    r_accs <= 50'(r_ps);
                end
                2'd1, 2'd2: begin
                    r_accc <= w_sumc;
                    r_accs <= w_sums;
                end
                default: begin
                    r_accc <= r_accc;
                    r_accs <= r_accs;
                end
            endcase
        end
        r_r12    <= 31'(w_r12w);
        r_cb     <= r_pcb;
        r_sb     <= r_psb;
        r_mz     <= sat19(w_z);
        r_mcos   <= r_hcos;
        r_msin   <= r_hsin;
        r_mpitch <= r_ppitch;
    end

    always_comb begin
        w_r12x = 63'(r_r12);
        w_cbx  = 63'(r_cb);
        w_sbx  = 63'(r_sb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= r_mv;
        end
        r_px     <= w_r12x * w_cbx;
        r_py     <= w_r12x * w_sbx;
        r_fz     <= r_mz;
        r_fcos   <= r_mcos;
        r_fsin   <= r_msin;
        r_fpitch <= r_mpitch;
    end

    always_comb begin
        w_xr = (r_px + 63'sd2199023255552) >>> 42;
        w_yr = (r_py + 63'sd2199023255552) >>> 42;
        w_x  = 24'(w_xr) + 24'(i_cfg.x_offs);
        w_y  = 24'(w_yr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_fv;
        end
        if (i_cfg.mode) begin
            o_pose_valid  <= 1'b1;
            o_x_pos       <= sat19(w_x);
            o_y_pos       <= sat19(w_y);
            o_z_pos       <= r_fz;
            o_pitch_cos   <= r_fcos;
            o_pitch_sin   <= r_fsin;
            o_pitch_angle <= r_fpitch;
        end else begin
            o_pose_valid  <= 1'b0;
            o_x_pos       <= '0;
            o_y_pos       <= '0;
            o_z_pos       <= '0;
            o_pitch_cos   <= '0;
            o_pitch_sin   <= '0;
            o_pitch_angle <= '0;
        end
    end

endmodule

### sv/arm_forward_kinematics.sv
`timescale 1ns / 1ps
// Forward kinematics of a yawing base carrying a planar three-link arm. New joint angles
// are taken while earlier sets are still in flight: a single chain of CORDIC cells computes
// the sine and cosine of the three cumulative pitch angles and of the base angle, one per
// cycle; o_busy is high after each start until the base angle enters the chain. A result
// appears on the outputs, strobed by o_done for one cycle, once the accumulator registers it;
// the receiver cannot stall it, so the result must be taken in that cycle.
module arm_forward_kinematics #(
    parameter int CORDIC_STAGES = afk_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [16:0] i_base_angle,
    input  logic signed [16:0] i_shoulder_angle,
    input  logic signed [16:0] i_elbow_angle,
    input  logic signed [16:0] i_wrist_angle,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_done,
    output logic               o_pose_valid,
    output logic signed [18:0] o_x_pos,
    output logic signed [18:0] o_y_pos,
    output logic signed [18:0] o_z_pos,
    output logic signed [15:0] o_pitch_cos,
    output logic signed [15:0] o_pitch_sin,
    output logic signed [15:0] o_pitch_angle
);
    import afk_pkg::*;

    `include "arm_forward_kinematics_assert.svh"

    t_cfg               r_cfg;
    logic               r_feeding;
    logic [1:0]         r_cnt;
    logic signed [18:0] r_ang [4];
    logic               w_accept;
    logic signed [15:0] w_wrapped;
    logic signed [15:0] w_folded;
    t_side              w_side [CORDIC_STAGES + 1];
    t_cord              w_cord [CORDIC_STAGES + 1];

    assign o_busy   = r_feeding && r_cnt != 2'd3;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= 1'b1;
            r_cfg.len1   <= '0;
            r_cfg.len2   <= '0;
            r_cfg.len3   <= '0;
            r_cfg.x_offs <= 16'sd232;
            r_cfg.z_offs <= 16'sd726;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_cfg.mode   <= i_cfg_data[0];
                REG_LINK1:  r_cfg.len1   <= i_cfg_data;
                REG_LINK2:  r_cfg.len2   <= i_cfg_data;
                REG_LINK3:  r_cfg.len3   <= i_cfg_data;
                REG_X_OFFS: r_cfg.x_offs <= i_cfg_data;
                REG_Z_OFFS: r_cfg.z_offs <= i_cfg_data;
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feeding <= 1'b0;
            r_cnt     <= '0;
        end else if (w_accept) begin
            r_feeding <= 1'b1;
            r_cnt     <= '0;
        end else if (r_feeding) begin
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                r_feeding <= 1'b0;
            end
        end
        if (w_accept) begin
            r_ang[0] <= 19'(i_shoulder_angle);
            r_ang[1] <= 19'(i_shoulder_angle) + 19'(i_elbow_angle);
            r_ang[2] <= 19'(i_shoulder_angle) + 19'(i_elbow_angle) + 19'(i_wrist_angle);
            r_ang[3] <= 19'(i_base_angle);
        end
    end

    always_comb begin
        w_wrapped = wrap_angle(r_ang[r_cnt]);
        w_folded  = w_wrapped;
        w_side[0].valid = r_feeding;
        w_side[0].idx   = r_cnt;
        w_side[0].neg   = 1'b0;
        w_side[0].pitch = wrap_angle(r_ang[2]);
        if (w_wrapped > 16'(QUARTER_TURN)) begin
            w_folded      = w_wrapped - 16'(HALF_TURN);
            w_side[0].neg = 1'b1;
        end else if (w_wrapped < -16'(QUARTER_TURN)) begin
            w_folded      = w_wrapped + 16'(HALF_TURN);
            w_side[0].neg = 1'b1;
        end
        w_cord[0].x = INV_GAIN_Q30;
        w_cord[0].y = '0;
        w_cord[0].z = 29'(w_folded) <<< 13;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        afk_cordic_cell #(
            .STAGE(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_side (w_side[g]),
            .i_cord (w_cord[g]),
            .o_side (w_side[g + 1]),
            .o_cord (w_cord[g + 1])
        );
    end

    afk_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_side       (w_side[CORDIC_STAGES]),
        .i_cord       (w_cord[CORDIC_STAGES]),
        .o_done       (o_done),
        .o_pose_valid (o_pose_valid),
        .o_x_pos      (o_x_pos),
        .o_y_pos      (o_y_pos),
        .o_z_pos      (o_z_pos),
        .o_pitch_cos  (o_pitch_cos),
        .o_pitch_sin  (o_pitch_sin),
        .o_pitch_angle(o_pitch_angle)
    );

    `AFK_ASSERT_NEXT(a_busy_after_start, w_accept, o_busy)
    `AFK_ASSERT_NEXT(a_done_spacing, o_done, !o_done)
    `AFK_ASSERT_IMP(a_disabled_zero, o_done && !r_cfg.mode, !o_pose_valid && o_x_pos == '0)

endmodule
